[rtl/core/assert_macros.svh]
// Assertion macros used by decimating_snapshot_log.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define DSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DSL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/dsl_pkg.sv]
package dsl_pkg;

    // Default number of records the log holds.
    localparam int CAPACITY_DEF = 32;

    // Command codes.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam int COUNT_OUT_W = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] stamp;
        logic [7:0]  health_in;
        logic [7:0]  progress_in;
        logic [9:0]  light_in;
        logic [9:0]  moisture_in;
        logic [9:0]  humidity_in;
        logic [7:0]  temp_code_in;
        logic        water_in;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [31:0]            stamp_out;
        logic [7:0]             health_out;
        logic [7:0]             progress_out;
        logic [9:0]             light_out;
        logic [9:0]             moisture_out;
        logic [9:0]             humidity_out;
        logic [7:0]             temp_code_out;
        logic                   water_out;
        logic [COUNT_OUT_W-1:0] count_out;
    } out_item_t;

    // One stored record, as held in the record memory.
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  health;
        logic [7:0]  progress;
        logic [9:0]  light;
        logic [9:0]  moisture;
        logic [9:0]  humidity;
        logic [7:0]  temp_code;
        logic        water;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_CMP_RDA,
        ST_CMP_RDB,
        ST_CMP_WR,
        ST_PUSH_WR
    } state_t;

    // Takes the record fields out of a command beat.
    function automatic rec_t item_to_rec(in_item_t it);
        rec_t r;
        r.stamp     = it.stamp;
        r.health    = it.health_in;
        r.progress  = it.progress_in;
        r.light     = it.light_in;
        r.moisture  = it.moisture_in;
        r.humidity  = it.humidity_in;
        r.temp_code = it.temp_code_in;
        r.water     = it.water_in;
        return r;
    endfunction

    // Merges two neighbouring records: floor of the mean of each numeric
    // field, and the water flags ANDed.
    function automatic rec_t merge_rec(rec_t a, rec_t b);
        rec_t        r;
        logic [32:0] s_stamp;
        logic [8:0]  s_health;
        logic [8:0]  s_progress;
        logic [10:0] s_light;
        logic [10:0] s_moisture;
        logic [10:0] s_humidity;
        logic [8:0]  s_temp;
        s_stamp     = {1'b0, a.stamp} + {1'b0, b.stamp};
        s_health    = {1'b0, a.health} + {1'b0, b.health};
        s_progress  = {1'b0, a.progress} + {1'b0, b.progress};
        s_light     = {1'b0, a.light} + {1'b0, b.light};
        s_moisture  = {1'b0, a.moisture} + {1'b0, b.moisture};
        s_humidity  = {1'b0, a.humidity} + {1'b0, b.humidity};
        s_temp      = {1'b0, a.temp_code} + {1'b0, b.temp_code};
        r.stamp     = s_stamp[32:1];
        r.health    = s_health[8:1];
        r.progress  = s_progress[8:1];
        r.light     = s_light[10:1];
        r.moisture  = s_moisture[10:1];
        r.humidity  = s_humidity[10:1];
        r.temp_code = s_temp[8:1];
        r.water     = a.water & b.water;
        return r;
    endfunction

endpackage

[rtl/core/dsl_ram.sv]
module dsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/decimating_snapshot_log.sv]
// A push with room, clear, an empty pop or the unused code gives its result in the
// cycle after the beat is taken; a found pop gives its result from ST_POP_RD.
// A push into a full log first halves the history (one read port): each record pair
// passes ST_CMP_RDA, ST_CMP_RDB and ST_CMP_WR; ST_PUSH_WR then stores the new record.
// Throughput: a beat per cycle while idle; a found pop or a full push raises busy.
// Results show for one cycle on done and are never stalled; rst_n empties the log at once.
`include "assert_macros.svh"

module decimating_snapshot_log #(
    parameter int CAPACITY = dsl_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dsl_pkg::in_item_t   item,
    output logic                done,
    output dsl_pkg::out_item_t  result
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int HALF   = (CAPACITY + 1) / 2;

    dsl_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    dsl_pkg::rec_t      hold_reg, hold_next;
    dsl_pkg::in_item_t  item_reg, item_next;
    dsl_pkg::out_item_t res_reg, res_next;
    logic               done_reg, done_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    dsl_pkg::rec_t       ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [dsl_pkg::REC_W-1:0] ram_rdata_raw;
    dsl_pkg::rec_t       ram_rdata;

    logic                accept;
    logic                full;
    logic                empty;
    logic [CNT_W-1:0]    count_dec;
    logic [ADDR_W:0]     q_wide;
    logic                q_ok;
    logic                last_pair;

    dsl_ram #(
        .WIDTH (dsl_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = dsl_pkg::rec_t'(ram_rdata_raw);

    // Handshake and derived status.
    assign busy      = (state_reg != dsl_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CNT_W'(1);
    assign q_wide    = {idx_reg, 1'b1};
    assign q_ok      = (q_wide < (ADDR_W + 1)'(CAPACITY));
    assign last_pair = (idx_reg == ADDR_W'(HALF - 1));
    assign done      = done_reg;
    assign result    = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsl_pkg::ST_IDLE:
            begin
                if (accept && item.command == dsl_pkg::CMD_PUSH && full)
                begin
                    state_next = dsl_pkg::ST_CMP_RDA;
                end
                else if (accept && item.command == dsl_pkg::CMD_POP && !empty)
                begin
                    state_next = dsl_pkg::ST_POP_RD;
                end
            end
            dsl_pkg::ST_POP_RD:  state_next = dsl_pkg::ST_IDLE;
            dsl_pkg::ST_CMP_RDA: state_next = dsl_pkg::ST_CMP_RDB;
            dsl_pkg::ST_CMP_RDB:
            begin
                state_next = q_ok ? dsl_pkg::ST_CMP_WR : dsl_pkg::ST_PUSH_WR;
            end
            dsl_pkg::ST_CMP_WR:
            begin
                state_next = last_pair ? dsl_pkg::ST_PUSH_WR : dsl_pkg::ST_CMP_RDA;
            end
            dsl_pkg::ST_PUSH_WR: state_next = dsl_pkg::ST_IDLE;
            default:             state_next = dsl_pkg::ST_IDLE;
        endcase
    end

    // Memory accesses, count update and the result beat.
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        hold_next  = hold_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = dsl_pkg::item_to_rec(item_reg);
        ram_re     = 1'b0;
        ram_raddr  = ADDR_W'({idx_reg, 1'b0});
        case (state_reg)
            dsl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = item;
                    case (item.command)
                        dsl_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                idx_next = '0;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = dsl_pkg::item_to_rec(item);
                                count_next = count_reg + CNT_W'(1);
                                done_next  = 1'b1;
                                res_next   = '0;
                            end
                        end
                        dsl_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                done_next = 1'b1;
                                res_next  = '0;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = count_dec[ADDR_W-1:0];
                                count_next = count_dec;
                            end
                        end
                        dsl_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                            res_next   = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = '0;
                        end
                    endcase
                end
            end
            dsl_pkg::ST_POP_RD:
            begin
                res_next.found         = 1'b1;
                res_next.stamp_out     = ram_rdata.stamp;
                res_next.health_out    = ram_rdata.health;
                res_next.progress_out  = ram_rdata.progress;
                res_next.light_out     = ram_rdata.light;
                res_next.moisture_out  = ram_rdata.moisture;
                res_next.humidity_out  = ram_rdata.humidity;
                res_next.temp_code_out = ram_rdata.temp_code;
                res_next.water_out     = ram_rdata.water;
                done_next              = 1'b1;
            end
            dsl_pkg::ST_CMP_RDA:
            begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'({idx_reg, 1'b0});
            end
            dsl_pkg::ST_CMP_RDB:
            begin
                hold_next = ram_rdata;
                if (q_ok)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(q_wide);
                end
                else
                begin
                    // An odd last record moves down unchanged.
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg;
                    ram_wdata  = ram_rdata;
                    count_next = CNT_W'(HALF);
                end
            end
            dsl_pkg::ST_CMP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = dsl_pkg::merge_rec(hold_reg, ram_rdata);
                if (last_pair)
                begin
                    count_next = CNT_W'(HALF);
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            dsl_pkg::ST_PUSH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[ADDR_W-1:0];
                ram_wdata  = dsl_pkg::item_to_rec(item_reg);
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                res_next   = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        if (done_next)
        begin
            res_next.count_out = dsl_pkg::COUNT_OUT_W'(count_next);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsl_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // The log never holds more than its capacity.
    `DSL_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")

    // A clear reports an empty log in the next cycle.
    `DSL_ASSERT(a_clear_result,
        accept && item.command == dsl_pkg::CMD_CLEAR |=> done && result.count_out == '0,
        "clear result wrong")

    // The push after a compaction lands just above the halved history.
    `DSL_ASSERT(a_half_count,
        state_reg == dsl_pkg::ST_PUSH_WR |-> count_reg == CNT_W'(HALF),
        "compaction count wrong")

    // A found record only ever comes from a pop read.
    `DSL_ASSERT(a_found_src,
        done && result.found |-> $past(state_reg) == dsl_pkg::ST_POP_RD,
        "found without pop read")

endmodule

[tb/sv/decimating_snapshot_log_tb.sv]
`timescale 1ns / 1ps

module decimating_snapshot_log_tb;

    localparam int LOG_DEPTH = dsl_pkg::CAPACITY_DEF;

    // The block ignores this command code; only the count comes back.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Records in the order they were logged, as the block should hold them.
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  health;
        logic [7:0]  progress;
        logic [9:0]  light;
        logic [9:0]  moisture;
        logic [9:0]  humidity;
        logic [7:0]  temp_code;
        logic        water;
    } snapshot_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    dsl_pkg::in_item_t   item = '0;
    logic                done;
    dsl_pkg::out_item_t  result;

    dsl_pkg::in_item_t   queued_commands[$];
    dsl_pkg::out_item_t  awaited_results[$];
    snapshot_t           snapshots[LOG_DEPTH];
    int                  held = 0;
    int                  idle_pct = 0;
    int                  mismatches = 0;
    logic                beat_taken = 1'b0;

    decimating_snapshot_log #(
        .CAPACITY (LOG_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor of the mean of two unsigned values, carried one bit wider.
    function automatic logic [31:0] mean_down(logic [31:0] x, logic [31:0] y);
        logic [32:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        return sum[32:1];
    endfunction

    // Halves the history: each pair of neighbours becomes one record.
    function automatic void halve_history();
        int        half;
        snapshot_t a;
        snapshot_t b;
        half = (held + 1) / 2;
        for (int i = 0; i < half; i++)
        begin
            a = snapshots[2 * i];
            if (2 * i + 1 < held)
            begin
                b           = snapshots[2 * i + 1];
                a.stamp     = mean_down(a.stamp, b.stamp);
                a.health    = 8'(mean_down(32'(a.health), 32'(b.health)));
                a.progress  = 8'(mean_down(32'(a.progress), 32'(b.progress)));
                a.light     = 10'(mean_down(32'(a.light), 32'(b.light)));
                a.moisture  = 10'(mean_down(32'(a.moisture), 32'(b.moisture)));
                a.humidity  = 10'(mean_down(32'(a.humidity), 32'(b.humidity)));
                a.temp_code = 8'(mean_down(32'(a.temp_code), 32'(b.temp_code)));
                a.water     = a.water & b.water;
            end
            snapshots[i] = a;
        end
        held = half;
    endfunction

    // Applies one command to the expected log and returns the result it gives.
    function automatic dsl_pkg::out_item_t log_command(dsl_pkg::in_item_t c);
        dsl_pkg::out_item_t r;
        snapshot_t          s;
        r = '0;
        case (c.command)
            dsl_pkg::CMD_PUSH:
            begin
                if (held >= LOG_DEPTH)
                    halve_history();
                s.stamp     = c.stamp;
                s.health    = c.health_in;
                s.progress  = c.progress_in;
                s.light     = c.light_in;
                s.moisture  = c.moisture_in;
                s.humidity  = c.humidity_in;
                s.temp_code = c.temp_code_in;
                s.water     = c.water_in;
                snapshots[held] = s;
                held++;
            end
            dsl_pkg::CMD_POP:
            begin
                if (held > 0)
                begin
                    held--;
                    s               = snapshots[held];
                    r.found         = 1'b1;
                    r.stamp_out     = s.stamp;
                    r.health_out    = s.health;
                    r.progress_out  = s.progress;
                    r.light_out     = s.light;
                    r.moisture_out  = s.moisture;
                    r.humidity_out  = s.humidity;
                    r.temp_code_out = s.temp_code;
                    r.water_out     = s.water;
                end
            end
            dsl_pkg::CMD_CLEAR:
                held = 0;
            default:
                ;
        endcase
        r.count_out = dsl_pkg::COUNT_OUT_W'(held);
        return r;
    endfunction

    // A field value biased towards its two extremes.
    function automatic logic [31:0] rand_bits(int bits);
        logic [31:0] mask;
        mask = 32'hFFFF_FFFF >> (32 - bits);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic dsl_pkg::in_item_t random_item(logic [1:0] cmd);
        dsl_pkg::in_item_t it;
        it.command      = cmd;
        it.stamp        = rand_bits(32);
        it.health_in    = 8'(rand_bits(8));
        it.progress_in  = 8'(rand_bits(8));
        it.light_in     = 10'(rand_bits(10));
        it.moisture_in  = 10'(rand_bits(10));
        it.humidity_in  = 10'(rand_bits(10));
        it.temp_code_in = 8'(rand_bits(8));
        it.water_in     = 1'(rand_bits(1));
        return it;
    endfunction

    // A command whose record fields are all zeros or all ones.
    function automatic dsl_pkg::in_item_t flat_item(logic [1:0] cmd, logic ones);
        dsl_pkg::in_item_t it;
        it         = ones ? '1 : '0;
        it.command = cmd;
        return it;
    endfunction

    // Random traffic: mostly fill and drain runs, with clears and odd commands between.
    task automatic queue_random_phase(int n_items);
        int added;
        int run;
        added = 0;
        // Every phase opens by overfilling the log so that it halves at least once.
        for (int i = 0; i < 40; i++)
            queued_commands.push_back(random_item(dsl_pkg::CMD_PUSH));
        added = 40;
        while (added < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    run = $urandom_range(20, 45);
                    for (int i = 0; i < run; i++)
                        queued_commands.push_back(random_item(
                            ($urandom_range(0, 9) == 0) ? dsl_pkg::CMD_POP
                                                        : dsl_pkg::CMD_PUSH));
                end
                5, 6, 7:
                begin
                    run = $urandom_range(4, 40);
                    for (int i = 0; i < run; i++)
                        queued_commands.push_back(random_item(
                            ($urandom_range(0, 7) == 0) ? dsl_pkg::CMD_PUSH
                                                        : dsl_pkg::CMD_POP));
                end
                8:
                begin
                    run = 1;
                    queued_commands.push_back(random_item(dsl_pkg::CMD_CLEAR));
                end
                default:
                begin
                    run = 3;
                    for (int i = 0; i < run; i++)
                        queued_commands.push_back(random_item(2'($urandom_range(0, 3))));
                end
            endcase
            added += run;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Waits until every queued command has gone in and every result has come back.
    task automatic wait_drained();
        while (queued_commands.size() != 0 || start || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Command driver: a new beat goes out once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || beat_taken))
        begin
            if (queued_commands.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                item  <= queued_commands.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor: checks each result, then predicts for a beat taken at this edge.
    always @(posedge clk)
    begin : monitor
        dsl_pkg::out_item_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("found", 32'(want.found), 32'(result.found));
                    check_field("stamp_out", want.stamp_out, result.stamp_out);
                    check_field("health_out", 32'(want.health_out), 32'(result.health_out));
                    check_field("progress_out", 32'(want.progress_out),
                                32'(result.progress_out));
                    check_field("light_out", 32'(want.light_out), 32'(result.light_out));
                    check_field("moisture_out", 32'(want.moisture_out),
                                32'(result.moisture_out));
                    check_field("humidity_out", 32'(want.humidity_out),
                                32'(result.humidity_out));
                    check_field("temp_code_out", 32'(want.temp_code_out),
                                32'(result.temp_code_out));
                    check_field("water_out", 32'(want.water_out), 32'(result.water_out));
                    check_field("count_out", 32'(want.count_out), 32'(result.count_out));
                end
            end
            if (start && !busy)
                awaited_results.push_back(log_command(item));
            beat_taken <= start && !busy;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        idle_pct = 7;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty log: pop, clear and the unused code.
        queued_commands.push_back(flat_item(dsl_pkg::CMD_POP, 1'b1));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_CLEAR, 1'b1));
        queued_commands.push_back(flat_item(CMD_UNUSED, 1'b1));
        // Records at both extremes and one in between, popped back newest first.
        queued_commands.push_back(flat_item(dsl_pkg::CMD_PUSH, 1'b1));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_PUSH, 1'b0));
        queued_commands.push_back(random_item(dsl_pkg::CMD_PUSH));
        queued_commands.push_back(flat_item(CMD_UNUSED, 1'b0));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_POP, 1'b0));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_POP, 1'b0));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_POP, 1'b0));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_POP, 1'b0));
        // A clear over a log holding two records, then an empty pop.
        queued_commands.push_back(flat_item(dsl_pkg::CMD_PUSH, 1'b1));
        queued_commands.push_back(random_item(dsl_pkg::CMD_PUSH));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_CLEAR, 1'b0));
        queued_commands.push_back(flat_item(dsl_pkg::CMD_POP, 1'b1));
        queue_random_phase(170);
        wait_drained();

        idle_pct = 61;
        queue_random_phase(180);
        wait_drained();

        idle_pct = 0;
        queue_random_phase(180);
        wait_drained();

        // Room for a late beat after a halving pass.
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("decimating_snapshot_log_tb: done, clean");
        else
            $display("decimating_snapshot_log_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("decimating_snapshot_log_tb: done, errors");
        $finish;
    end

endmodule
